// File: sv/dda_pkg.sv
// shared constants, payload types and state encodings of the dda line rasterizer
`default_nettype none

package dda_pkg;

    localparam int COORD_BITS     = 12;
    localparam int DIM_BITS       = 12;
    localparam int ADDR_BITS      = 22;
    localparam int COLOUR_BITS    = 32;
    localparam int MAX_DIM        = 2048;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = DIM_BITS'(480);

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } command_t;

    typedef struct packed
    {
        command_t                       command;
        logic signed [COORD_BITS-1:0]   start_x;
        logic signed [COORD_BITS-1:0]   start_y;
        logic signed [COORD_BITS-1:0]   end_x;
        logic signed [COORD_BITS-1:0]   end_y;
        logic        [COLOUR_BITS-1:0]  colour;
    } line_cmd_t;

    typedef struct packed
    {
        logic signed [COORD_BITS-1:0]   pixel_x;
        logic signed [COORD_BITS-1:0]   pixel_y;
        logic                           on_screen;
        logic        [ADDR_BITS-1:0]    pixel_address;
        logic        [COLOUR_BITS-1:0]  pixel_colour;
        logic                           last;
    } pixel_t;

    // rounded pixel handed from the stepper to the clip and address stage
    typedef struct packed
    {
        logic signed [COORD_BITS:0]     px;
        logic signed [COORD_BITS:0]     py;
        logic        [COLOUR_BITS-1:0]  colour;
        logic                           last;
    } pix_req_t;

    typedef enum logic [1:0]
    {
        DIV_IDLE,
        DIV_SETUP,
        DIV_RUN,
        DIV_FINISH
    } div_state_t;

endpackage

`default_nettype wire

// File: sv/dda_line_rasterizer.sv
// top level of the dda line rasterizer: config, line stepper and rounding
//
//  port group  | direction | handshake              | content
//  cfg         | in        | cfg_we                 | frame_width / frame_height writes
//  cmd         | in        | cmd_valid / cmd_stall  | start or step request
//  pix         | out       | pix_valid / pix_stall  | one pixel per active step request
//
// a step request's pixel is registered in s1 and then in the output register before pix
// a start request holds cmd_stall high while the bit-serial divider runs
// a step with no active line is taken and gives no pixel
// reset sets the frame to 640x480 and leaves no line active
// pix_stall backs up through two pixel registers before cmd_stall rises
`default_nettype none

module dda_line_rasterizer #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [dda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [dda_pkg::DIM_BITS-1:0]        cfg_data,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_stall,
    input  wire dda_pkg::line_cmd_t                  cmd,
    output logic                                     pix_valid,
    input  wire logic                                pix_stall,
    output dda_pkg::pixel_t                          pix
);
    import dda_pkg::*;

    localparam int POS_W  = COORD_BITS + FRAC_BITS + 2;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int LEFT_W = COORD_BITS + 1;
    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

    logic [DIM_BITS-1:0]     frame_width_reg, frame_width_next;
    logic [DIM_BITS-1:0]     frame_height_reg, frame_height_next;
    logic                    line_active_reg, line_active_next;
    logic [LEFT_W-1:0]       pixels_left_reg, pixels_left_next;
    logic signed [POS_W-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_W-1:0] pos_y_reg, pos_y_next;
    logic [COLOUR_BITS-1:0]  colour_reg, colour_next;

    logic                     cmd_accept;
    logic                     start_accept;
    logic                     step_accept;
    logic signed [LEFT_W-1:0] dx;
    logic signed [LEFT_W-1:0] dy;
    logic                     div_busy;
    logic                     div_done;
    logic [LEFT_W-1:0]        div_len;
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic [POS_W-1:0]         rnd_x;
    logic [POS_W-1:0]         rnd_y;
    logic                     pix_req_valid;
    pix_req_t                 pix_req;
    logic                     pix_ready;

    assign cmd_stall    = div_busy || !pix_ready;
    assign cmd_accept   = cmd_valid && !cmd_stall;
    assign start_accept = cmd_accept && (cmd.command == CMD_START);
    assign step_accept  = cmd_accept && (cmd.command == CMD_STEP);

    assign dx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
    assign dy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};

    dda_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (start_accept),
        .dx     (dx),
        .dy     (dy),
        .busy   (div_busy),
        .done   (div_done),
        .len    (div_len),
        .step_x (step_x),
        .step_y (step_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            line_active_reg  <= 1'b0;
            pixels_left_reg  <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            line_active_reg  <= line_active_next;
            pixels_left_reg  <= pixels_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_x_reg  <= pos_x_next;
        pos_y_reg  <= pos_y_next;
        colour_reg <= colour_next;
    end

    always_comb
    begin
        // round half away from zero: subtract one LSB before the floor when negative
        rnd_x = pos_x_reg + HALF - POS_W'(pos_x_reg[POS_W-1]);
        rnd_y = pos_y_reg + HALF - POS_W'(pos_y_reg[POS_W-1]);

        pix_req_valid  = step_accept && line_active_reg;
        pix_req.px     = rnd_x[FRAC_BITS +: COORD_BITS+1];
        pix_req.py     = rnd_y[FRAC_BITS +: COORD_BITS+1];
        pix_req.colour = colour_reg;
        pix_req.last   = (pixels_left_reg == LEFT_W'(1));

        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        line_active_next  = line_active_reg;
        pixels_left_next  = pixels_left_reg;
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        colour_next       = colour_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        if (start_accept)
        begin
            pos_x_next       = {{2{cmd.start_x[COORD_BITS-1]}}, cmd.start_x, {FRAC_BITS{1'b0}}};
            pos_y_next       = {{2{cmd.start_y[COORD_BITS-1]}}, cmd.start_y, {FRAC_BITS{1'b0}}};
            colour_next      = cmd.colour;
            line_active_next = 1'b0;
        end
        else if (pix_req_valid)
        begin
            pos_x_next       = pos_x_reg + {{(POS_W-STEP_W){step_x[STEP_W-1]}}, step_x};
            pos_y_next       = pos_y_reg + {{(POS_W-STEP_W){step_y[STEP_W-1]}}, step_y};
            pixels_left_next = pixels_left_reg - LEFT_W'(1);
            if (pix_req.last)
            begin
                line_active_next = 1'b0;
            end
        end

        // increments ready: the line becomes active with len+1 pixels
        if (div_done)
        begin
            pixels_left_next = div_len + LEFT_W'(1);
            line_active_next = 1'b1;
        end
    end

    dda_pix u_pix (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .req_valid    (pix_req_valid),
        .req          (pix_req),
        .ready        (pix_ready),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .pix          (pix)
    );

    a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (pixels_left_reg != '0))
        else $error("active line with no pixels left");

    a_start_drops_line: assert property (@(posedge clk) disable iff (!rst_n)
        start_accept |=> (div_busy && !line_active_reg))
        else $error("start request did not launch the divider");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_req_valid && pix_req.last) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_done_starts_line: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> (line_active_reg && !div_busy))
        else $error("line not active after divider finished");

endmodule

`default_nettype wire

// File: sv/dda_div.sv
// bit-serial restoring divider forming both signed line increments
`default_nettype none

module dda_div #(
    parameter int FRAC_BITS = dda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire logic signed [dda_pkg::COORD_BITS:0] dx,
    input  wire logic signed [dda_pkg::COORD_BITS:0] dy,
    output logic                                   busy,
    output logic                                   done,
    output logic        [dda_pkg::COORD_BITS:0]    len,
    output logic signed [FRAC_BITS+1:0]            step_x,
    output logic signed [FRAC_BITS+1:0]            step_y
);
    import dda_pkg::*;

    localparam int MAG_W  = COORD_BITS + 1;
    localparam int REM_W  = COORD_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(FRAC_BITS);

    div_state_t               state_reg, state_next;
    logic signed [MAG_W-1:0]  dx_reg, dx_next;
    logic signed [MAG_W-1:0]  dy_reg, dy_next;
    logic        [REM_W-1:0]  rem_x_reg, rem_x_next;
    logic        [REM_W-1:0]  rem_y_reg, rem_y_next;
    logic        [MAG_W-1:0]  len_reg, len_next;
    logic        [Q_W-1:0]    q_x_reg, q_x_next;
    logic        [Q_W-1:0]    q_y_reg, q_y_next;
    logic                     neg_x_reg, neg_x_next;
    logic                     neg_y_reg, neg_y_next;
    logic        [CNT_W-1:0]  count_reg, count_next;
    logic signed [STEP_W-1:0] step_x_reg, step_x_next;
    logic signed [STEP_W-1:0] step_y_reg, step_y_next;

    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic              ge_x;
    logic              ge_y;
    logic [REM_W-1:0]  rem_x_sub;
    logic [REM_W-1:0]  rem_y_sub;
    logic [STEP_W-1:0] q_x_ext;
    logic [STEP_W-1:0] q_y_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        rem_x_reg  <= rem_x_next;
        rem_y_reg  <= rem_y_next;
        len_reg    <= len_next;
        q_x_reg    <= q_x_next;
        q_y_reg    <= q_y_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        count_reg  <= count_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
    end

    always_comb
    begin
        mag_x     = dx_reg[MAG_W-1] ? MAG_W'(-dx_reg) : MAG_W'(dx_reg);
        mag_y     = dy_reg[MAG_W-1] ? MAG_W'(-dy_reg) : MAG_W'(dy_reg);
        ge_x      = rem_x_reg >= REM_W'(len_reg);
        ge_y      = rem_y_reg >= REM_W'(len_reg);
        rem_x_sub = ge_x ? (rem_x_reg - REM_W'(len_reg)) : rem_x_reg;
        rem_y_sub = ge_y ? (rem_y_reg - REM_W'(len_reg)) : rem_y_reg;
        q_x_ext   = STEP_W'(q_x_reg);
        q_y_ext   = STEP_W'(q_y_reg);

        state_next  = state_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        rem_x_next  = rem_x_reg;
        rem_y_next  = rem_y_reg;
        len_next    = len_reg;
        q_x_next    = q_x_reg;
        q_y_next    = q_y_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        count_next  = count_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;

        unique case (state_reg)
            DIV_IDLE:
            begin
                if (load)
                begin
                    dx_next    = dx;
                    dy_next    = dy;
                    state_next = DIV_SETUP;
                end
            end
            DIV_SETUP:
            begin
                rem_x_next = REM_W'(mag_x);
                rem_y_next = REM_W'(mag_y);
                len_next   = (mag_x >= mag_y) ? mag_x : mag_y;
                neg_x_next = dx_reg[MAG_W-1];
                neg_y_next = dy_reg[MAG_W-1];
                count_next = '0;
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                // integer bit first, then one fraction bit per cycle
                q_x_next   = {q_x_reg[Q_W-2:0], ge_x};
                q_y_next   = {q_y_reg[Q_W-2:0], ge_y};
                rem_x_next = {rem_x_sub[REM_W-2:0], 1'b0};
                rem_y_next = {rem_y_sub[REM_W-2:0], 1'b0};
                count_next = count_reg + CNT_W'(1);
                if (count_reg == LAST_COUNT)
                begin
                    state_next = DIV_FINISH;
                end
            end
            DIV_FINISH:
            begin
                // zero-length line keeps zero increments
                if (len_reg == '0)
                begin
                    step_x_next = '0;
                    step_y_next = '0;
                end
                else
                begin
                    step_x_next = neg_x_reg ? -q_x_ext : q_x_ext;
                    step_y_next = neg_y_reg ? -q_y_ext : q_y_ext;
                end
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != DIV_IDLE);
    assign done   = (state_reg == DIV_FINISH);
    assign len    = len_reg;
    assign step_x = step_x_reg;
    assign step_y = step_y_reg;

endmodule

`default_nettype wire

// File: sv/dda_pix.sv
// clip and address stage with output register for the pixel channel
`default_nettype none

module dda_pix (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [dda_pkg::DIM_BITS-1:0]  frame_width,
    input  wire logic [dda_pkg::DIM_BITS-1:0]  frame_height,
    input  wire logic                          req_valid,
    input  wire dda_pkg::pix_req_t             req,
    output logic                               ready,
    output logic                               pix_valid,
    input  wire logic                          pix_stall,
    output dda_pkg::pixel_t                    pix
);
    import dda_pkg::*;

    localparam int CMP_W  = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
    localparam int PROD_W = COORD_BITS + DIM_BITS;
    localparam logic [DIM_BITS-1:0] DIM_LIMIT = DIM_BITS'(MAX_DIM);

    logic     s1_valid_reg, s1_valid_next;
    pix_req_t s1_reg, s1_next;
    logic     out_valid_reg, out_valid_next;
    pixel_t   out_reg, out_next;

    logic                  out_load;
    logic [DIM_BITS-1:0]   width_c;
    logic [DIM_BITS-1:0]   height_c;
    logic [COORD_BITS-1:0] px_u;
    logic [COORD_BITS-1:0] py_u;
    logic                  x_ok;
    logic                  y_ok;
    logic                  on;
    logic [PROD_W-1:0]     product;
    logic [PROD_W-1:0]     addr_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        out_load = !out_valid_reg || !pix_stall;
        ready    = !s1_valid_reg || out_load;

        // frame size saturates at the largest supported dimension
        width_c  = (frame_width > DIM_LIMIT) ? DIM_LIMIT : frame_width;
        height_c = (frame_height > DIM_LIMIT) ? DIM_LIMIT : frame_height;

        px_u     = s1_reg.px[COORD_BITS-1:0];
        py_u     = s1_reg.py[COORD_BITS-1:0];
        x_ok     = !s1_reg.px[COORD_BITS] && (CMP_W'(px_u) < CMP_W'(width_c));
        y_ok     = !s1_reg.py[COORD_BITS] && (CMP_W'(py_u) < CMP_W'(height_c));
        on       = x_ok && y_ok;
        product  = PROD_W'(py_u) * PROD_W'(width_c);
        addr_sum = product + PROD_W'(px_u);

        s1_valid_next = ready ? req_valid : s1_valid_reg;
        s1_next       = (ready && req_valid) ? req : s1_reg;

        out_valid_next = out_load ? s1_valid_reg : out_valid_reg;
        out_next       = out_reg;
        if (out_load && s1_valid_reg)
        begin
            out_next.pixel_x       = s1_reg.px[COORD_BITS-1:0];
            out_next.pixel_y       = s1_reg.py[COORD_BITS-1:0];
            out_next.on_screen     = on;
            out_next.pixel_address = on ? addr_sum[ADDR_BITS-1:0] : '0;
            out_next.pixel_colour  = s1_reg.colour;
            out_next.last          = s1_reg.last;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

`default_nettype wire
